### rtl/i2a_pkg.sv
// Shared constants, control word type and microcode table of the integer to ASCII formatter.
// Depends on nothing; imported by rtl/integer_to_ascii_formatter.sv.
package i2a_pkg;

	localparam int CMD_W = 3;

	localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HEXL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_HEXU = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PTR  = 3'd4;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_LOWA  = 8'h61;
	localparam logic [7:0] ASCII_UPA   = 8'h41;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [7:0] ASCII_X     = 8'h78;

	// Reciprocal of ten for 32-bit values: q = (x * RECIP10) >> RECIP_SH.
	localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
	localparam int          RECIP_SH = 35;
	localparam logic [3:0]  DEC_BASE = 4'd10;

	// Microcode step addresses.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] S_WAIT = 3'd0;
	localparam logic [STEP_W-1:0] S_DISP = 3'd1;
	localparam logic [STEP_W-1:0] S_DMUL = 3'd2;
	localparam logic [STEP_W-1:0] S_DDIG = 3'd3;
	localparam logic [STEP_W-1:0] S_HDIG = 3'd4;
	localparam logic [STEP_W-1:0] S_LEN  = 3'd5;
	localparam logic [STEP_W-1:0] S_EMIT = 3'd6;

	// Datapath operations.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
	localparam logic [OP_W-1:0] OP_NOP  = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
	localparam logic [OP_W-1:0] OP_DDIG = 3'd3;
	localparam logic [OP_W-1:0] OP_HDIG = 3'd4;
	localparam logic [OP_W-1:0] OP_LEN  = 3'd5;
	localparam logic [OP_W-1:0] OP_EMIT = 3'd6;

	// Branch conditions.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS = 3'd0;
	localparam logic [COND_W-1:0] C_GO     = 3'd1;
	localparam logic [COND_W-1:0] C_HEX    = 3'd2;
	localparam logic [COND_W-1:0] C_MORE   = 3'd3;
	localparam logic [COND_W-1:0] C_DONE   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target_t;
		logic [STEP_W-1:0] target_f;
	} ctrl_word_t;

	// The program: one control word per step, taken branch first.
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		unique case (step)
			S_WAIT:  cw = '{OP_LOAD, C_GO,     S_DISP, S_WAIT};
			S_DISP:  cw = '{OP_NOP,  C_HEX,    S_HDIG, S_DMUL};
			S_DMUL:  cw = '{OP_MUL,  C_ALWAYS, S_DDIG, S_DDIG};
			S_DDIG:  cw = '{OP_DDIG, C_MORE,   S_DMUL, S_LEN};
			S_HDIG:  cw = '{OP_HDIG, C_MORE,   S_HDIG, S_LEN};
			S_LEN:   cw = '{OP_LEN,  C_ALWAYS, S_EMIT, S_EMIT};
			S_EMIT:  cw = '{OP_EMIT, C_DONE,   S_WAIT, S_EMIT};
			default: cw = '{OP_NOP,  C_ALWAYS, S_WAIT, S_WAIT};
		endcase
		return cw;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < DEC_BASE) begin
			c = ASCII_ZERO + {4'd0, d};
		end else if (upper) begin
			c = ASCII_UPA + {4'd0, d - DEC_BASE};
		end else begin
			c = ASCII_LOWA + {4'd0, d - DEC_BASE};
		end
		return c;
	endfunction

endpackage

### rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: microcoded sequencer and its datapath.
// Depends on rtl/i2a_pkg.sv for the control word type, the program table and the codes.

// Each input transfer carries a command and a number and yields its text as a run of output
// transfers, one ASCII character each, most significant first: signed or unsigned 32-bit
// decimal, lowercase or uppercase 32-bit hex, or a pointer of POINTER_BITS bits as "0x" and
// lowercase hex. Every character carries the run length and a last mark. An item with an
// unknown command is taken and produces nothing. One item is worked at a time. An item is
// taken in the wait step and dispatched in the dispatch step; each decimal digit then takes
// a multiply step (a 32 by 32 reciprocal multiply) and a digit step (a remainder and digit
// push), each hex digit a single step, a length step sizes the run, and the emit step sends
// one character per cycle while the output side keeps up. The last character sits in an
// output register, so the next item is taken while it waits.
module integer_to_ascii_formatter #(
	parameter int POINTER_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [i2a_pkg::CMD_W-1:0] command,
	input  logic [63:0]              number,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               character,
	output logic [4:0]               text_length,
	output logic                     last
);
	import i2a_pkg::*;

	// The magnitude register must hold a 32-bit value or a full pointer.
	localparam int MAG_W = (POINTER_BITS > 32) ? POINTER_BITS : 32;
	// Digit buffer: ten decimal digits, or one hex digit per pointer nibble.
	localparam int HEX_N = (MAG_W + 3) / 4;
	localparam int DIG_N = (HEX_N > 10) ? HEX_N : 10;
	localparam int BUF_W = DIG_N * 4;
	localparam int NDIG_W = $clog2(DIG_N + 1);

	// Sequencer state.
	logic [STEP_W-1:0] step_q;
	ctrl_word_t        cw;
	logic              taken;

	// Datapath registers.
	logic [CMD_W-1:0]  cmd_q;
	logic              neg_q;
	logic [MAG_W-1:0]  mag_q;
	logic [63:0]       prod_q;
	logic [BUF_W-1:0]  buf_q;
	logic [NDIG_W-1:0] ndig_q;
	logic [15:0]       pre_q;
	logic [1:0]        pre_cnt_q;
	logic [4:0]        len_q;
	logic [4:0]        remain_q;

	// Output register.
	logic              out_valid_q;
	logic [7:0]        char_q;
	logic [4:0]        tlen_q;
	logic              last_q;

	logic              go;
	logic              slot_free;
	logic              more;
	logic [28:0]       quot;
	logic [31:0]       quot10;
	logic [31:0]       rem_full;
	logic [3:0]        dec_digit;
	logic [31:0]       low32;
	logic [31:0]       low32_neg;
	logic [7:0]        emit_char;
	logic [1:0]        pre_len;

	assign cw = ucode(step_q);

	// The input side is open only in the waiting step; unknown commands are taken and dropped.
	assign in_ready  = (cw.op == OP_LOAD);
	assign go        = in_valid && in_ready && (command <= CMD_PTR);
	assign slot_free = !out_valid_q || out_ready;

	// Divide by ten from the registered reciprocal product.
	assign quot      = prod_q[63:RECIP_SH];
	assign quot10    = {quot[28:0], 3'b000} + {2'b00, quot[28:0], 1'b0};
	assign rem_full  = mag_q[31:0] - quot10;
	assign dec_digit = rem_full[3:0];

	// A decimal step continues while the quotient is nonzero, a hex step while nibbles remain.
	assign more = (cw.op == OP_DDIG) ? (quot != '0) : (mag_q[MAG_W-1:4] != '0);

	assign low32     = number[31:0];
	assign low32_neg = 32'd0 - low32;

	// Prefix characters go first, then digits from the low end of the buffer.
	assign emit_char = (pre_cnt_q != 2'd0) ? pre_q[15:8]
	                 : digit_char(buf_q[3:0], cmd_q == CMD_HEXU);

	assign pre_len = (cmd_q == CMD_PTR) ? 2'd2 : (neg_q ? 2'd1 : 2'd0);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS: taken = 1'b1;
			C_GO:     taken = go;
			C_HEX:    taken = (cmd_q != CMD_SDEC) && (cmd_q != CMD_UDEC);
			C_MORE:   taken = more;
			C_DONE:   taken = slot_free && (remain_q == 5'd1);
			default:  taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else begin
			step_q <= taken ? cw.target_t : cw.target_f;
		end
	end

	// Datapath, driven by the operation field of the current control word.
	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (go) begin
					cmd_q  <= command;
					neg_q  <= (command == CMD_SDEC) && low32[31];
					ndig_q <= '0;
					if (command == CMD_PTR) begin
						mag_q <= MAG_W'(number[POINTER_BITS-1:0]);
					end else if ((command == CMD_SDEC) && low32[31]) begin
						mag_q <= MAG_W'(low32_neg);
					end else begin
						mag_q <= MAG_W'(low32);
					end
				end
			end
			OP_MUL: begin
				prod_q <= mag_q[31:0] * RECIP10;
			end
			OP_DDIG: begin
				buf_q  <= {buf_q[BUF_W-5:0], dec_digit};
				mag_q  <= MAG_W'(quot);
				ndig_q <= ndig_q + NDIG_W'(1);
			end
			OP_HDIG: begin
				buf_q  <= {buf_q[BUF_W-5:0], mag_q[3:0]};
				mag_q  <= mag_q >> 4;
				ndig_q <= ndig_q + NDIG_W'(1);
			end
			OP_LEN: begin
				len_q     <= 5'(ndig_q) + {3'd0, pre_len};
				remain_q  <= 5'(ndig_q) + {3'd0, pre_len};
				pre_cnt_q <= pre_len;
				pre_q     <= (cmd_q == CMD_PTR) ? {ASCII_ZERO, ASCII_X} : {ASCII_MINUS, 8'h00};
			end
			OP_EMIT: begin
				if (slot_free) begin
					remain_q <= remain_q - 5'd1;
					if (pre_cnt_q != 2'd0) begin
						pre_q     <= {pre_q[7:0], 8'h00};
						pre_cnt_q <= pre_cnt_q - 2'd1;
					end else begin
						buf_q <= buf_q >> 4;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded by an emit step when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cw.op == OP_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cw.op == OP_EMIT) && slot_free) begin
			char_q <= emit_char;
			tlen_q <= len_q;
			last_q <= (remain_q == 5'd1);
		end
	end

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign text_length = tlen_q;
	assign last        = last_q;

endmodule

### dv/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_ascii_formatter: directed table, then random items.
// Depends on rtl/i2a_pkg.sv for the command codes and on rtl/integer_to_ascii_formatter.sv.

module tb_integer_to_ascii_formatter;
	import i2a_pkg::*;

	localparam int PTR_BITS     = 64;
	localparam int RESET_CYCLES = 5;
	localparam int MAX_IDLE     = 6;
	localparam int RANDOM_ITEMS = 325;
	// The slowest item is a full pointer, eighteen characters.
	localparam int DRAIN_CYCLES = 64;
	localparam int TIMEOUT_NS   = 4_000_000;

	// Command codes the block does not define; such a transfer is taken and dropped.
	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	// One output character as the block should present it.
	typedef struct packed {
		logic [7:0] ch;
		logic [4:0] len;
		logic       last;
	} text_char_t;

	// A row of the directed table. When typed is set, txt is the text the row must give;
	// otherwise the text comes from the formatter model below.
	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [63:0]      num;
		bit               typed;
		string            txt;
	} stim_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic [CMD_W-1:0] command   = '0;
	logic [63:0]      number    = '0;
	logic             out_ready = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic [7:0]       character;
	logic [4:0]       text_length;
	logic             last;

	// Characters still owed by the block, oldest first.
	text_char_t expected_chars[$];
	stim_row_t  dir_table[$];

	int n_errors    = 0;
	int n_formatted = 0;
	int n_dropped   = 0;
	int n_chars     = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;

	integer_to_ascii_formatter #(
		.POINTER_BITS(PTR_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.number     (number),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.text_length(text_length),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Formats one item the way the block should. Decimal and hex use the low 32 bits; a
	// pointer uses the low PTR_BITS bits and gets a "0x" prefix. An unknown command gives an
	// empty text, which means no characters at all.
	function automatic string format_text(input logic [CMD_W-1:0] cmd, input logic [63:0] num);
		string       lower_set = "0123456789abcdef";
		string       upper_set = "0123456789ABCDEF";
		string       digits;
		string       prefix;
		logic [63:0] mag;
		logic [4:0]  base;
		bit          upper;
		int          idx;
		digits = "";
		prefix = "";
		upper  = 1'b0;
		base   = 5'd16;
		mag    = {32'd0, num[31:0]};
		case (cmd)
			CMD_SDEC: begin
				base = 5'd10;
				// The magnitude of the most negative value still fits in 32 unsigned bits.
				if (num[31]) begin
					mag    = {32'd0, 32'(-num[31:0])};
					prefix = "-";
				end
			end
			CMD_UDEC: begin
				base = 5'd10;
			end
			CMD_HEXL: begin
				upper = 1'b0;
			end
			CMD_HEXU: begin
				upper = 1'b1;
			end
			CMD_PTR: begin
				mag    = num & ({64{1'b1}} >> (64 - PTR_BITS));
				prefix = "0x";
			end
			default: begin
				return "";
			end
		endcase
		// Digits come out least significant first, so each one is put in front.
		do begin
			idx    = int'(mag % base);
			digits = $sformatf("%c%s", upper ? upper_set[idx] : lower_set[idx], digits);
			mag    = mag / base;
		end while (mag != 0);
		return {prefix, digits};
	endfunction

	// Turns a text into the run of characters the block owes, each with length and last mark.
	function automatic void queue_text(input string txt);
		for (int k = 0; k < txt.len(); k++) begin
			expected_chars.push_back('{ch: txt[k], len: 5'(txt.len()),
				last: (k == txt.len() - 1)});
		end
	endfunction

	// Presents one item, waits for its transfer, then records the characters it owes. The gap
	// before it is drawn per item; a zero gap keeps valid high straight into the next item.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [63:0] num,
		input string txt);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		number   <= num;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		queue_text(txt);
		if (txt.len() == 0) begin
			n_dropped++;
		end else begin
			n_formatted++;
		end
	endtask

	// Stimulus: reset, the directed table, then random items, then the drain and verdict.
	initial begin : stimulus
		logic [CMD_W-1:0] valid_cmds[5];
		logic [CMD_W-1:0] cmd;
		logic [63:0]      num;
		string            txt;
		int               sh;
		valid_cmds = '{CMD_SDEC, CMD_UDEC, CMD_HEXL, CMD_HEXU, CMD_PTR};

		// Extremes, every command and the special cases are typed in; the remaining rows
		// are ordinary values left to the model.
		dir_table = '{
			'{CMD_SDEC,  64'h0000_0000_0000_0000, 1'b1, "0"},
			'{CMD_SDEC,  64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647"},
			'{CMD_SDEC,  64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
			'{CMD_SDEC,  64'h0000_0000_FFFF_FFFF, 1'b1, "-1"},
			'{CMD_SDEC,  64'hDEAD_BEEF_0000_007B, 1'b1, "123"},
			'{CMD_UDEC,  64'h0000_0000_0000_0000, 1'b1, "0"},
			'{CMD_UDEC,  64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"},
			'{CMD_UDEC,  64'hFFFF_FFFF_0000_0001, 1'b1, "1"},
			'{CMD_HEXL,  64'h0000_0000_0000_0000, 1'b1, "0"},
			'{CMD_HEXL,  64'h0000_0000_FFFF_FFFF, 1'b1, "ffffffff"},
			'{CMD_HEXU,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "FFFFFFFF"},
			'{CMD_HEXU,  64'h1234_5678_ABCD_EF09, 1'b1, "ABCDEF09"},
			'{CMD_PTR,   64'h0000_0000_0000_0000, 1'b1, "0x0"},
			'{CMD_PTR,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xffffffffffffffff"},
			'{CMD_PTR,   64'h0000_0000_0000_0001, 1'b1, "0x1"},
			'{CMD_RSVD5, 64'h0000_0000_0000_007B, 1'b1, ""},
			'{CMD_RSVD6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ""},
			'{CMD_RSVD7, 64'h0000_0000_0000_0000, 1'b1, ""},
			'{CMD_SDEC,  64'h0000_0000_075B_CD15, 1'b0, ""},
			'{CMD_SDEC,  64'h5555_5555_FFFF_FFF6, 1'b0, ""},
			'{CMD_UDEC,  64'h0000_0000_8000_0000, 1'b0, ""},
			'{CMD_HEXL,  64'hAAAA_AAAA_0000_ABCD, 1'b0, ""},
			'{CMD_PTR,   64'h0000_7FFF_1234_5678, 1'b0, ""}
		};

		// Reset is held from time zero and released on a clock edge, once only.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			txt = dir_table[i].typed ? dir_table[i].txt
				: format_text(dir_table[i].cmd, dir_table[i].num);
			send_item(dir_table[i].cmd, dir_table[i].num, txt);
		end

		// Random items. The shift spreads magnitudes so that every digit count shows up,
		// while the bits above the used width stay random. About one item in sixteen
		// carries an unknown command; those do not count toward the total.
		while (n_formatted < dir_table.size() - 3 + RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
			sh = $urandom_range(0, 63);
			if ($urandom_range(0, 15) == 0) begin
				cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
			end else begin
				cmd = valid_cmds[$urandom_range(0, 4)];
			end
			if (cmd == CMD_PTR) begin
				num = {$urandom, $urandom} >> sh;
			end else begin
				num = {$urandom, $urandom >> (sh % 32)};
			end
			if ($urandom_range(0, 15) == 0) num[31:0] = '0;
			txt = format_text(cmd, num);
			send_item(cmd, num, txt);
		end
		in_valid <= 1'b0;

		// Wait for every owed character, then watch a while longer for stray ones.
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d formatted items in all five formats and %0d unknown commands,",
			n_formatted, n_dropped);
		$display("with %0d characters checked and %0d mismatches.", n_chars, n_errors);
		if (n_errors == 0) begin
			$display("** integer_to_ascii_formatter: PASSED **");
		end else begin
			$display("** integer_to_ascii_formatter: FAILED **");
		end
		$finish;
	end

	// Output side: a stall is drawn before every character, with stretches of none. Each
	// transfer is compared field by field with the oldest owed character.
	initial begin : result_checker
		int         stall;
		text_char_t owed;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 23) == 0) recv_steady = !recv_steady;
			stall = recv_steady ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			n_chars++;
			if (expected_chars.size() == 0) begin
				n_errors++;
				$display("%0t: character %h len %0d last %0b arrived with none expected",
					$time, character, text_length, last);
			end else begin
				owed = expected_chars.pop_front();
				if (character !== owed.ch) begin
					n_errors++;
					$display("%0t: character expected %h actual %h", $time, owed.ch, character);
				end
				if (text_length !== owed.len) begin
					n_errors++;
					$display("%0t: text_length expected %0d actual %0d", $time, owed.len,
						text_length);
				end
				if (last !== owed.last) begin
					n_errors++;
					$display("%0t: last expected %0b actual %0b", $time, owed.last, last);
				end
			end
		end
	end

	// Watchdog: a hung handshake or missing characters end the run here.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d characters still expected", $time,
			expected_chars.size());
		$display("** integer_to_ascii_formatter: FAILED **");
		$finish;
	end

endmodule
